[rtl/core/csrmv_pkg.sv]
// ----------------------------------------------------------------------------
// csrmv_pkg
// shared types and constants of the compressed-row sparse matrix-vector core
// ----------------------------------------------------------------------------
package csrmv_pkg;

    // store depth and field widths
    localparam int MAX_DIM = 1024;
    localparam int IDX_W   = $clog2(MAX_DIM);
    localparam int CNT_W   = IDX_W + 1;
    localparam int VAL_W   = 32;
    localparam int ACC_W   = 2 * VAL_W;

    // packed stream widths, padded to whole bytes
    localparam int S_DATA_W = ((IDX_W + VAL_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((IDX_W + ACC_W + 7) / 8) * 8;

    // saturation limits of the accumulator
    localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // item kinds carried in s_tuser
    typedef enum logic [1:0] {
        ACT_LOAD    = 2'd0,
        ACT_NONZERO = 2'd1,
        ACT_EMPTY   = 2'd2,
        ACT_RESTART = 2'd3
    } action_t;

    // command into the accumulate stage
    typedef struct packed {
        logic             fire;
        action_t          action;
        logic             ends_row;
        logic [ACC_W-1:0] product;
    } acc_cmd_t;

    // result out of the accumulate stage
    typedef struct packed {
        logic             emit;
        logic [IDX_W-1:0] row;
        logic [ACC_W-1:0] sum;
        logic             saturated;
        logic             last_row;
    } acc_res_t;

endpackage

[rtl/core/csrmv_accum.sv]
// ----------------------------------------------------------------------------
// csrmv_accum
// saturating q32.32 accumulator, row counter and row result formation
// ----------------------------------------------------------------------------
module csrmv_accum (
    input  logic                      clk,
    input  logic                      rst_n,
    input  csrmv_pkg::acc_cmd_t       cmd,
    input  logic [csrmv_pkg::CNT_W-1:0] row_count,
    output csrmv_pkg::acc_res_t       res
);
    import csrmv_pkg::*;

    logic [ACC_W-1:0] acc_reg, acc_next;
    logic             ovf_reg, ovf_next;
    logic [IDX_W-1:0] row_reg, row_next;

    logic [ACC_W-1:0] raw_sum;
    logic [ACC_W-1:0] sat_sum;
    logic             add_ovf;
    logic             sat_flag;
    logic [CNT_W-1:0] eff_rows;
    logic             is_last;
    logic [IDX_W-1:0] row_adv;

    // saturating add of the incoming product
    always_comb
    begin
        raw_sum  = acc_reg + cmd.product;
        add_ovf  = (acc_reg[ACC_W-1] == cmd.product[ACC_W-1]) &&
                   (raw_sum[ACC_W-1] != acc_reg[ACC_W-1]);
        sat_sum  = add_ovf ? (acc_reg[ACC_W-1] ? ACC_MIN : ACC_MAX) : raw_sum;
        sat_flag = ovf_reg | add_ovf;
    end

    // effective row count and row counter step
    always_comb
    begin
        if (row_count == '0 || row_count > CNT_W'(MAX_DIM))
            eff_rows = CNT_W'(MAX_DIM);
        else
            eff_rows = row_count;
        is_last = {1'b0, row_reg} == (eff_rows - CNT_W'(1));
        row_adv = is_last ? '0 : row_reg + IDX_W'(1);
    end

    // next state and emitted row
    always_comb
    begin
        acc_next      = acc_reg;
        ovf_next      = ovf_reg;
        row_next      = row_reg;
        res.emit      = 1'b0;
        res.row       = row_reg;
        res.sum       = '0;
        res.saturated = 1'b0;
        res.last_row  = is_last;
        if (cmd.fire)
        begin
            unique case (cmd.action)
                ACT_LOAD:
                begin
                end
                ACT_NONZERO:
                begin
                    if (cmd.ends_row)
                    begin
                        res.emit      = 1'b1;
                        res.sum       = sat_sum;
                        res.saturated = sat_flag;
                        acc_next      = '0;
                        ovf_next      = 1'b0;
                        row_next      = row_adv;
                    end
                    else
                    begin
                        acc_next = sat_sum;
                        ovf_next = sat_flag;
                    end
                end
                ACT_EMPTY:
                begin
                    res.emit = 1'b1;
                    acc_next = '0;
                    ovf_next = 1'b0;
                    row_next = row_adv;
                end
                ACT_RESTART:
                begin
                    acc_next = '0;
                    ovf_next = 1'b0;
                    row_next = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            ovf_reg <= 1'b0;
            row_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
            ovf_reg <= ovf_next;
            row_reg <= row_next;
        end
    end

    // a restart always returns to row zero
    a_restart_row: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fire && cmd.action == ACT_RESTART |=> row_reg == '0)
        else $error("row counter not cleared by restart");

    // every emitted row leaves a clean accumulator
    a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        res.emit |=> acc_reg == '0 && !ovf_reg)
        else $error("accumulator not cleared after row end");

    // the last row wraps the counter back to zero
    a_last_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        res.emit && res.last_row |=> row_reg == '0)
        else $error("row counter did not wrap after last row");

endmodule

[rtl/core/csr_sparse_matvec_core.sv]
// ----------------------------------------------------------------------------
// csr_sparse_matvec_core
// compressed-row sparse matrix times dense vector, q16.16 in, q32.32 out
// ----------------------------------------------------------------------------
//  channel  dir  fields (lowest bit first)
//  s_*      in   tdata: index[9:0] value[41:10]; tuser: action; tlast: ends_row
//  m_*      out  tdata: row[9:0] sum[73:10]; tuser: saturated; tlast: last_row
//  cfg_*    in   cfg_data: row_count, write always taken
//
//  one item per cycle unless a held result stalls: vector read, multiply and
//  accumulate are three stages, the last one closing into the output register,
//  so a row result reaches m_tvalid through stage 1, stage 2 and that register
//  the single-port vector memory is read as the item is taken; a load written
//  in one cycle is seen by a nonzero taken in the next
//  reset clears control and accumulator state only; vector entries stay
//  undefined until loaded, and there is no clearing pass
//  a held result stalls a row-ending item in the accumulate stage and all
//  items behind it; items that produce no row pass the held result
// ----------------------------------------------------------------------------
module csr_sparse_matvec_core (
    input  logic                           clk,
    input  logic                           rst_n,
    // input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [csrmv_pkg::S_DATA_W-1:0] s_tdata,   // index, value
    input  logic [1:0]                     s_tuser,   // action
    input  logic                           s_tlast,   // ends_row
    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [csrmv_pkg::M_DATA_W-1:0] m_tdata,   // row, sum
    output logic                           m_tuser,   // saturated
    output logic                           m_tlast,   // last_row
    // configuration
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [csrmv_pkg::CNT_W-1:0]    cfg_data   // row_count
);
    import csrmv_pkg::*;

    // vector store
    logic [VAL_W-1:0] vec_mem [MAX_DIM];

    logic [CNT_W-1:0] row_count_reg;

    // stage 1: item taken, vector element being read
    logic             v1_reg;
    action_t          act1_reg;
    logic [VAL_W-1:0] val1_reg;
    logic             ends1_reg;
    logic [VAL_W-1:0] elem1_reg;

    // stage 2: product ready for accumulation
    logic             v2_reg;
    action_t          act2_reg;
    logic             ends2_reg;
    logic [ACC_W-1:0] prod2_reg;

    // output register
    logic             ov_reg;
    logic [IDX_W-1:0] orow_reg;
    logic [ACC_W-1:0] osum_reg;
    logic             osat_reg;
    logic             olast_reg;

    logic             in_fire;
    logic             adv1;
    logic             adv2;
    logic             emits2;
    logic [IDX_W-1:0] in_index;
    logic [VAL_W-1:0] in_value;
    logic [ACC_W-1:0] product;
    acc_cmd_t         cmd;
    acc_res_t         res;

    // input unpacking
    assign in_index = s_tdata[IDX_W-1:0];
    assign in_value = s_tdata[IDX_W+VAL_W-1:IDX_W];

    // pipeline handshake
    always_comb
    begin
        emits2   = (act2_reg == ACT_EMPTY) || (act2_reg == ACT_NONZERO && ends2_reg);
        adv2     = v2_reg && (!emits2 || !ov_reg || m_tready);
        adv1     = v1_reg && (!v2_reg || adv2);
        s_tready = !v1_reg || adv1;
        in_fire  = s_tvalid && s_tready;
    end

    // configuration register, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            row_count_reg <= CNT_W'(MAX_DIM);
        else if (cfg_valid)
            row_count_reg <= cfg_data;
    end

    // vector memory: write on load, registered read on every transfer
    always_ff @(posedge clk)
    begin
        if (in_fire && action_t'(s_tuser) == ACT_LOAD)
            vec_mem[in_index] <= in_value;
        if (in_fire)
            elem1_reg <= vec_mem[in_index];
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
                v1_reg <= 1'b1;
            else if (adv1)
                v1_reg <= 1'b0;
            if (adv1)
                v2_reg <= 1'b1;
            else if (adv2)
                v2_reg <= 1'b0;
        end
    end

    // stage 1 payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            act1_reg  <= action_t'(s_tuser);
            val1_reg  <= in_value;
            ends1_reg <= s_tlast;
        end
    end

    // stage 2: signed multiply, exact q32.32 product
    assign product = ACC_W'($signed(val1_reg) * $signed(elem1_reg));

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            act2_reg  <= act1_reg;
            ends2_reg <= ends1_reg;
            prod2_reg <= product;
        end
    end

    // accumulate stage
    always_comb
    begin
        cmd.fire     = adv2;
        cmd.action   = act2_reg;
        cmd.ends_row = ends2_reg;
        cmd.product  = prod2_reg;
    end

    csrmv_accum u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .row_count (row_count_reg),
        .res       (res)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (res.emit)
            ov_reg <= 1'b1;
        else if (m_tready)
            ov_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res.emit)
        begin
            orow_reg  <= res.row;
            osum_reg  <= res.sum;
            osat_reg  <= res.saturated;
            olast_reg <= res.last_row;
        end
    end

    // result packing
    assign m_tvalid = ov_reg;
    assign m_tdata  = {{(M_DATA_W-IDX_W-ACC_W){1'b0}}, osum_reg, orow_reg};
    assign m_tuser  = osat_reg;
    assign m_tlast  = olast_reg;

    // a new row never overwrites a result still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && !m_tready |-> !res.emit)
        else $error("row result overwritten while stalled");

endmodule
